// File: rtl/rotation_to_euler_angles_top_macros.svh
// Assertion macros shared by the RTL. In synthesis they expand to nothing.
`ifndef ROTATION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define ROTATION_TO_EULER_ANGLES_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/rte_pkg.sv
package rte_pkg;

    // Number of CORDIC iterations; only the first TABLE_LEN have table entries.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int IDX_W         = $clog2(TABLE_LEN);

    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int ROLL_W = 15;

    // Square root of 16 * (a^2 + b^2), one result bit per step.
    localparam int PROD_W   = 31;
    localparam int SUM_W    = 32;
    localparam int SQ_W     = 36;
    localparam int SQ_STEPS = 18;
    localparam int MAG_W    = 18;

    // CORDIC lane widths: lane input, vector with guard bits, fine angle.
    localparam int LW = 20;
    localparam int CW = 30;
    localparam int ZW = 33;

    localparam int GUARD_SHIFT    = 8;
    localparam int FRAC_SHIFT     = 16;
    localparam int ROLL_NUM_SHIFT = 2;

    localparam logic signed [ZW-1:0] FINE_HALF_TURN    = 33'sd1509949440;
    localparam logic signed [ZW-1:0] FINE_QUARTER_TURN = 33'sd754974720;
    localparam logic signed [ZW-1:0] ROUND_HALF        = 33'sd32768;
    localparam logic signed [ZW-1:0] HALF_TURN_Z       = 33'sd23040;

    localparam logic signed [OUT_W-1:0]  OUT_QUARTER_TURN = 16'sd11520;
    localparam logic signed [ROLL_W-1:0] ROLL_LIMIT       = 15'sd11520;

    // atan(2^-i) in units of 2^-23 degree, rounded to nearest.
    localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        33'sd377487360, 33'sd222843801, 33'sd117744544, 33'sd59768969,
        33'sd30000467,  33'sd15014858,  33'sd7509261,   33'sd3754860,
        33'sd1877459,   33'sd938733,    33'sd469367,    33'sd234683,
        33'sd117342,    33'sd58671,     33'sd29335,     33'sd14668,
        33'sd7334,      33'sd3667,      33'sd1833,      33'sd917,
        33'sd458,       33'sd229,       33'sd115,       33'sd57
    };

    typedef struct packed {
        logic signed [IN_W-1:0] r00;
        logic signed [IN_W-1:0] r10;
        logic signed [IN_W-1:0] r20;
        logic signed [IN_W-1:0] r21;
        logic signed [IN_W-1:0] r22;
    } t_side;

    typedef struct packed {
        logic            vld;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
        t_side           side;
    } t_sqrt;

    typedef struct packed {
        logic                 vld;
        logic                 hold;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

endpackage

// File: rtl/rotation_to_euler_angles_top.sv
// ZYX Euler angles from a rotation matrix. Give five matrix entries in signed Q1.14
// with start high; the item is taken at any clock edge where busy is low, and busy is
// low in every cycle except during reset and the first cycle after it, so one item
// per clock is sustained. Yaw, pitch and roll appear on the result ports, in units of
// 1/128 degree, for exactly one cycle marked by o_strobe, in the order the items came.
// There is no way to hold results off: the receiver must take each one in the cycle
// it is shown. Each item passes through two chains of cells: an 18-step square-root
// chain that forms the magnitude used for roll, followed by three parallel CORDIC
// lanes of NUM_CELLS cells each, with a register at every step.
module rotation_to_euler_angles_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [rte_pkg::IN_W-1:0]      i_first_row_first,
    input  logic signed [rte_pkg::IN_W-1:0]      i_second_row_first,
    input  logic signed [rte_pkg::IN_W-1:0]      i_third_row_first,
    input  logic signed [rte_pkg::IN_W-1:0]      i_third_row_second,
    input  logic signed [rte_pkg::IN_W-1:0]      i_third_row_third,
    output logic                                 o_strobe,
    output logic signed [rte_pkg::OUT_W-1:0]     o_yaw_deg,
    output logic signed [rte_pkg::OUT_W-1:0]     o_pitch_deg,
    output logic signed [rte_pkg::ROLL_W-1:0]    o_roll_deg
);
    import rte_pkg::*;

    // Ready flag: cleared by reset so that no item is taken while the pipeline clears.
    logic r_rdy;

    // First stage: the two squares for the roll magnitude, with the matrix riding along.
    logic                     r_p_vld;
    logic [PROD_W-1:0]        r_p21;
    logic [PROD_W-1:0]        r_p22;
    t_side                    r_p_side;
    t_side                    n_p_side;
    logic signed [2*IN_W-1:0] w_m21;
    logic signed [2*IN_W-1:0] w_m22;

    // Second stage: the sum of squares times 16 enters the square-root chain.
    t_sqrt            r_s;
    t_sqrt            n_s;
    logic [SUM_W-1:0] w_sum;
    t_sqrt            w_sq [SQ_STEPS+1];

    // Lane inputs taken from the end of the square-root chain.
    t_side                  w_side;
    logic signed [IN_W-1:0] w_r00;
    logic signed [IN_W-1:0] w_r10;
    logic signed [IN_W-1:0] w_r20;
    logic signed [IN_W-1:0] w_r21;
    logic signed [IN_W-1:0] w_r22;
    logic signed [LW-1:0]   w_roll_y;
    logic signed [LW-1:0]   w_roll_x;
    logic signed [LW-1:0]   w_r20e;

    logic                    w_vld_yaw;
    logic                    w_vld_pitch;
    logic                    w_vld_roll;
    logic signed [OUT_W-1:0] w_ang_yaw;
    logic signed [OUT_W-1:0] w_ang_pitch;
    logic signed [OUT_W-1:0] w_ang_roll;

    // Output register.
    logic                     r_strobe;
    logic signed [OUT_W-1:0]  r_yaw;
    logic signed [OUT_W-1:0]  r_pitch;
    logic signed [ROLL_W-1:0] r_roll;
    logic signed [ROLL_W-1:0] n_roll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy = ~r_rdy;

    // The squares are never negative and stay below 2^31.
    always_comb begin
        w_m21        = i_third_row_second * i_third_row_second;
        w_m22        = i_third_row_third * i_third_row_third;
        n_p_side.r00 = i_first_row_first;
        n_p_side.r10 = i_second_row_first;
        n_p_side.r20 = i_third_row_first;
        n_p_side.r21 = i_third_row_second;
        n_p_side.r22 = i_third_row_third;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= start & r_rdy;
        end
        r_p21    <= w_m21[PROD_W-1:0];
        r_p22    <= w_m22[PROD_W-1:0];
        r_p_side <= n_p_side;
    end

    // Scaling by 16 gives the root two more fraction bits than the inputs carry.
    always_comb begin
        w_sum    = SUM_W'(r_p21) + SUM_W'(r_p22);
        n_s.vld  = r_p_vld;
        n_s.rem  = {w_sum, {(SQ_W-SUM_W){1'b0}}};
        n_s.res  = '0;
        n_s.side = r_p_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign w_sq[0] = r_s;

    // Cell k tries the root bit of weight 2^(SQ_STEPS-1-k), most significant first.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        rte_sqrt_cell u_sqrt (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_k    (IDX_W'(SQ_STEPS - 1 - k)),
            .i_d    (w_sq[k]),
            .o_q    (w_sq[k+1])
        );
    end

    // Roll uses -r20 times 4 so that both sides of its atan2 share the root's format.
    always_comb begin
        w_side   = w_sq[SQ_STEPS].side;
        w_r00    = w_side.r00;
        w_r10    = w_side.r10;
        w_r20    = w_side.r20;
        w_r21    = w_side.r21;
        w_r22    = w_side.r22;
        w_r20e   = LW'(w_r20);
        w_roll_y = -(w_r20e <<< ROLL_NUM_SHIFT);
        w_roll_x = $signed({{(LW-MAG_W){1'b0}}, w_sq[SQ_STEPS].res[MAG_W-1:0]});
    end

    rte_atan2 u_yaw (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_sq[SQ_STEPS].vld),
        .i_y    (LW'(w_r10)),
        .i_x    (LW'(w_r00)),
        .o_vld  (w_vld_yaw),
        .o_ang  (w_ang_yaw)
    );

    rte_atan2 u_pitch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_sq[SQ_STEPS].vld),
        .i_y    (LW'(w_r21)),
        .i_x    (LW'(w_r22)),
        .o_vld  (w_vld_pitch),
        .o_ang  (w_ang_pitch)
    );

    rte_atan2 u_roll (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_sq[SQ_STEPS].vld),
        .i_y    (w_roll_y),
        .i_x    (w_roll_x),
        .o_vld  (w_vld_roll),
        .o_ang  (w_ang_roll)
    );

    // Yaw is the negated angle, so a half turn of +180 comes out as -180 and
    // the reverse. Roll is limited to a quarter turn either way.
    always_comb begin
        if (w_ang_roll > OUT_QUARTER_TURN) begin
            n_roll = ROLL_LIMIT;
        end else if (w_ang_roll < -OUT_QUARTER_TURN) begin
            n_roll = -ROLL_LIMIT;
        end else begin
            n_roll = w_ang_roll[ROLL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_vld_yaw;
        end
        r_yaw   <= -w_ang_yaw;
        r_pitch <= w_ang_pitch;
        r_roll  <= n_roll;
    end

    assign o_strobe    = r_strobe;
    assign o_yaw_deg   = r_yaw;
    assign o_pitch_deg = r_pitch;
    assign o_roll_deg  = r_roll;

`include "rotation_to_euler_angles_top_macros.svh"

    // The three lanes share one valid chain in effect and must never drift apart.
    `RTE_ASSERT_IMP(a_lanes_in_step, i_clk, i_rst_n, 1'b1, (w_vld_yaw == w_vld_pitch) && (w_vld_yaw == w_vld_roll), "CORDIC lanes out of step")
    // An accepted item reaches the first stage at the next edge.
    `RTE_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, start && !busy, r_p_vld, "accepted item lost at entry")
    // The strobe follows the lane output in the next cycle, both ways.
    `RTE_ASSERT_NXT(a_strobe_follows, i_clk, i_rst_n, w_vld_yaw, o_strobe, "result not strobed")
    `RTE_ASSERT_NXT(a_no_extra_strobe, i_clk, i_rst_n, !w_vld_yaw, !o_strobe, "strobe without a result")
    // Roll stays within a quarter turn.
    `RTE_ASSERT_IMP(a_roll_range, i_clk, i_rst_n, o_strobe, (o_roll_deg <= ROLL_LIMIT) && (o_roll_deg >= -ROLL_LIMIT), "roll out of range")

endmodule

// File: rtl/rte_sqrt_cell.sv
module rte_sqrt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rte_pkg::IDX_W-1:0] i_k,
    input  rte_pkg::t_sqrt            i_d,
    output rte_pkg::t_sqrt            o_q
);
    import rte_pkg::*;

    t_sqrt           r_q;
    t_sqrt           n_q;
    logic [SQ_W-1:0] w_bit;
    logic [SQ_W:0]   w_trial;

    // One step of the digit-by-digit root: try the bit 4^k against the remainder.
    always_comb begin
        w_bit   = SQ_W'(1) << {i_k, 1'b0};
        w_trial = {1'b0, i_d.res} + {1'b0, w_bit};
        n_q     = i_d;
        if ({1'b0, i_d.rem} >= w_trial) begin
            n_q.rem = i_d.rem - w_trial[SQ_W-1:0];
            n_q.res = (i_d.res >> 1) + w_bit;
        end else begin
            n_q.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/rte_cordic_cell.sv
module rte_cordic_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rte_pkg::IDX_W-1:0] i_idx,
    input  rte_pkg::t_cordic          i_d,
    output rte_pkg::t_cordic          o_q
);
    import rte_pkg::*;

    t_cordic              r_q;
    t_cordic              n_q;
    logic signed [CW-1:0] w_x;
    logic signed [CW-1:0] w_y;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [ZW-1:0] w_ang;

    // Vectoring rotation: drive y toward zero and collect the angle in z.
    // A held item already carries its final angle and passes unchanged.
    always_comb begin
        w_x   = i_d.x;
        w_y   = i_d.y;
        w_xs  = w_x >>> i_idx;
        w_ys  = w_y >>> i_idx;
        w_ang = ATAN_TAB[i_idx];
        n_q   = i_d;
        if (!i_d.hold) begin
            if (!w_y[CW-1]) begin
                n_q.x = w_x + w_ys;
                n_q.y = w_y - w_xs;
                n_q.z = i_d.z + w_ang;
            end else begin
                n_q.x = w_x - w_ys;
                n_q.y = w_y + w_xs;
                n_q.z = i_d.z - w_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/rte_atan2.sv
module rte_atan2 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic signed [rte_pkg::LW-1:0]    i_y,
    input  logic signed [rte_pkg::LW-1:0]    i_x,
    output logic                             o_vld,
    output logic signed [rte_pkg::OUT_W-1:0] o_ang
);
    import rte_pkg::*;

    t_cordic              r_c0;
    t_cordic              n_c0;
    t_cordic              w_c [NUM_CELLS+1];
    logic signed [LW-1:0] w_xn;
    logic signed [LW-1:0] w_yn;
    logic signed [CW-1:0] w_xe;
    logic signed [CW-1:0] w_ye;
    logic signed [ZW-1:0] w_zf;
    logic signed [ZW-1:0] w_zr;
    logic signed [ZW-1:0] w_sh;

    logic                    r_vld;
    logic signed [OUT_W-1:0] r_ang;
    logic signed [OUT_W-1:0] n_ang;

    // Entry: settle the axis cases outright, fold the left half plane over.
    always_comb begin
        w_xn = i_x;
        w_yn = i_y;
        n_c0.vld  = i_vld;
        n_c0.hold = 1'b0;
        n_c0.z    = '0;
        if (i_y == '0) begin
            n_c0.hold = 1'b1;
            n_c0.z    = i_x[LW-1] ? FINE_HALF_TURN : '0;
        end else if (i_x == '0) begin
            n_c0.hold = 1'b1;
            n_c0.z    = i_y[LW-1] ? -FINE_QUARTER_TURN : FINE_QUARTER_TURN;
        end else if (i_x[LW-1]) begin
            n_c0.z = i_y[LW-1] ? -FINE_HALF_TURN : FINE_HALF_TURN;
            w_xn   = -i_x;
            w_yn   = -i_y;
        end
        w_xe   = CW'(w_xn);
        w_ye   = CW'(w_yn);
        n_c0.x = w_xe <<< GUARD_SHIFT;
        n_c0.y = w_ye <<< GUARD_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
        end else begin
            r_c0 <= n_c0;
        end
    end

    assign w_c[0] = r_c0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        rte_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_idx  (IDX_W'(g)),
            .i_d    (w_c[g]),
            .o_q    (w_c[g+1])
        );
    end

    // Round to 1/128 degree, ties upward, and clamp to a half turn.
    always_comb begin
        w_zf = w_c[NUM_CELLS].z;
        w_zr = w_zf + ROUND_HALF;
        w_sh = w_zr >>> FRAC_SHIFT;
        if (w_sh > HALF_TURN_Z) begin
            n_ang = HALF_TURN_Z[OUT_W-1:0];
        end else if (w_sh < -HALF_TURN_Z) begin
            n_ang = -HALF_TURN_Z[OUT_W-1:0];
        end else begin
            n_ang = w_sh[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_c[NUM_CELLS].vld;
        end
        r_ang <= n_ang;
    end

    assign o_vld = r_vld;
    assign o_ang = r_ang;

endmodule
